### hdl/qrs_pkg.sv
// Shared types, widths and codes for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int COEF_FRAC = 8;
    localparam int OUT_FRAC  = 16;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int DISC_W    = 2 * COEF_W + 2;
    localparam int NEGB_W    = COEF_W + OUT_FRAC - COEF_FRAC + 1;
    localparam int SHIFT     = 2 * (OUT_FRAC - COEF_FRAC);
    localparam int SQ_W      = (DISC_W - 1 + SHIFT + 1) / 2;
    localparam int RAD_W     = 2 * SQ_W;
    localparam int REM_W     = SQ_W + 2;
    localparam int NUM_W     = ((NEGB_W > SQ_W) ? NEGB_W : SQ_W) + 2;
    localparam int DVD_W     = NUM_W + COEF_FRAC;
    localparam int DSR_W     = COEF_W + 1;
    localparam int ROOT_W    = 32;

    typedef enum logic [1:0] {
        KIND_TWO   = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_CPLX  = 2'd2,
        KIND_AZERO = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic signed [DISC_W-1:0]   disc;
        logic signed [NEGB_W-1:0]   negb;
        logic                       a_neg;
        logic        [DSR_W-1:0]    dmag;
    } t_sq_tag;

    typedef struct packed {
        t_kind                      kind;
        logic signed [DISC_W-1:0]   disc;
        logic                       neg1;
        logic                       neg2;
    } t_dv_tag;

endpackage

### hdl/qrs_disc.sv
// Discriminant stages: products, then b*b-4ac, kind and square root radicand.
module qrs_disc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_a,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_b,
    input  logic signed [qrs_pkg::COEF_W-1:0]   i_c,
    output logic                                o_vld,
    output logic        [qrs_pkg::RAD_W-1:0]    o_rad,
    output qrs_pkg::t_sq_tag                    o_tag
);

    logic                                r_vld1;
    logic signed [qrs_pkg::PROD_W-1:0]   r_bb;
    logic signed [qrs_pkg::PROD_W-1:0]   r_ac;
    logic signed [qrs_pkg::COEF_W-1:0]   r_a;
    logic signed [qrs_pkg::COEF_W-1:0]   r_b;

    logic signed [qrs_pkg::DISC_W-1:0]   n_disc;
    logic        [qrs_pkg::DISC_W-1:0]   n_absd;
    logic signed [qrs_pkg::DSR_W-1:0]    n_a2;
    qrs_pkg::t_sq_tag                    n_tag;
    logic        [qrs_pkg::RAD_W-1:0]    n_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            o_vld  <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            o_vld  <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bb  <= i_b * i_b;
        r_ac  <= i_a * i_c;
        r_a   <= i_a;
        r_b   <= i_b;
        o_tag <= n_tag;
        o_rad <= n_rad;
    end

    always_comb begin
        n_disc = {{2{r_bb[qrs_pkg::PROD_W-1]}}, r_bb} - {r_ac, 2'b00};
        n_absd = n_disc[qrs_pkg::DISC_W-1] ? -n_disc : n_disc;
        n_a2   = {r_a, 1'b0};
        n_rad  = {{(qrs_pkg::RAD_W - qrs_pkg::DISC_W - qrs_pkg::SHIFT + 1){1'b0}},
                  n_absd[qrs_pkg::DISC_W-2:0], {qrs_pkg::SHIFT{1'b0}}};
        n_tag.disc  = n_disc;
        n_tag.negb  = -$signed({r_b[qrs_pkg::COEF_W-1], r_b,
                                {(qrs_pkg::OUT_FRAC - qrs_pkg::COEF_FRAC){1'b0}}});
        n_tag.a_neg = r_a[qrs_pkg::COEF_W-1];
        n_tag.dmag  = n_a2[qrs_pkg::DSR_W-1] ? -n_a2 : n_a2;
        if (r_a == '0) begin
            n_tag.kind = qrs_pkg::KIND_AZERO;
        end else if (n_disc[qrs_pkg::DISC_W-1]) begin
            n_tag.kind = qrs_pkg::KIND_CPLX;
        end else if (n_disc == '0) begin
            n_tag.kind = qrs_pkg::KIND_ONE;
        end else begin
            n_tag.kind = qrs_pkg::KIND_TWO;
        end
    end

endmodule

### hdl/qrs_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module qrs_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [qrs_pkg::RAD_W-1:0]         i_rad,
    input  qrs_pkg::t_sq_tag                  i_tag,
    output logic                              o_vld,
    output logic [qrs_pkg::SQ_W-1:0]          o_root,
    output qrs_pkg::t_sq_tag                  o_tag
);

    localparam int N = qrs_pkg::SQ_W;

    logic                          r_vld  [N];
    logic [qrs_pkg::REM_W-1:0]     r_rem  [N];
    logic [qrs_pkg::SQ_W-1:0]      r_root [N];
    logic [qrs_pkg::RAD_W-1:0]     r_rad  [N];
    qrs_pkg::t_sq_tag              r_tag  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                          p_vld;
        logic [qrs_pkg::REM_W-1:0]     p_rem;
        logic [qrs_pkg::SQ_W-1:0]      p_root;
        logic [qrs_pkg::RAD_W-1:0]     p_rad;
        qrs_pkg::t_sq_tag              p_tag;
        logic [qrs_pkg::REM_W-1:0]     n_cur;
        logic [qrs_pkg::REM_W-1:0]     n_trial;
        logic                          n_bit;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_tag  = r_tag[k-1];
        end

        always_comb begin
            n_cur   = {p_rem[qrs_pkg::REM_W-3:0], p_rad[qrs_pkg::RAD_W-1 -: 2]};
            n_trial = {p_root, 2'b01};
            n_bit   = (n_cur >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_bit ? n_cur - n_trial : n_cur;
            r_root[k] <= {p_root[qrs_pkg::SQ_W-2:0], n_bit};
            r_rad[k]  <= {p_rad[qrs_pkg::RAD_W-3:0], 2'b00};
            r_tag[k]  <= p_tag;
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_tag  = r_tag[N-1];

endmodule

### hdl/qrs_div.sv
// Pipelined two-lane restoring divider on magnitudes, one quotient bit per stage.
module qrs_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic [qrs_pkg::DVD_W-1:0]         i_dvd1,
    input  logic [qrs_pkg::DVD_W-1:0]         i_dvd2,
    input  logic [qrs_pkg::DSR_W-1:0]         i_dsr,
    input  qrs_pkg::t_dv_tag                  i_tag,
    output logic                              o_vld,
    output logic [qrs_pkg::DVD_W-1:0]         o_quo1,
    output logic [qrs_pkg::DVD_W-1:0]         o_quo2,
    output qrs_pkg::t_dv_tag                  o_tag
);

    localparam int N = qrs_pkg::DVD_W;

    logic                          r_vld  [N];
    logic [qrs_pkg::DSR_W-1:0]     r_rem1 [N];
    logic [qrs_pkg::DSR_W-1:0]     r_rem2 [N];
    logic [qrs_pkg::DVD_W-1:0]     r_dvd1 [N];
    logic [qrs_pkg::DVD_W-1:0]     r_dvd2 [N];
    logic [qrs_pkg::DSR_W-1:0]     r_dsr  [N];
    qrs_pkg::t_dv_tag              r_tag  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                          p_vld;
        logic [qrs_pkg::DSR_W-1:0]     p_rem1;
        logic [qrs_pkg::DSR_W-1:0]     p_rem2;
        logic [qrs_pkg::DVD_W-1:0]     p_dvd1;
        logic [qrs_pkg::DVD_W-1:0]     p_dvd2;
        logic [qrs_pkg::DSR_W-1:0]     p_dsr;
        qrs_pkg::t_dv_tag              p_tag;
        logic [qrs_pkg::DSR_W:0]       n_cur1;
        logic [qrs_pkg::DSR_W:0]       n_cur2;
        logic [qrs_pkg::DSR_W:0]       n_sub1;
        logic [qrs_pkg::DSR_W:0]       n_sub2;
        logic                          n_q1;
        logic                          n_q2;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rem1 = '0;
            assign p_rem2 = '0;
            assign p_dvd1 = i_dvd1;
            assign p_dvd2 = i_dvd2;
            assign p_dsr  = i_dsr;
            assign p_tag  = i_tag;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem1 = r_rem1[k-1];
            assign p_rem2 = r_rem2[k-1];
            assign p_dvd1 = r_dvd1[k-1];
            assign p_dvd2 = r_dvd2[k-1];
            assign p_dsr  = r_dsr[k-1];
            assign p_tag  = r_tag[k-1];
        end

        always_comb begin
            n_cur1 = {p_rem1, p_dvd1[qrs_pkg::DVD_W-1]};
            n_cur2 = {p_rem2, p_dvd2[qrs_pkg::DVD_W-1]};
            n_q1   = (n_cur1 >= {1'b0, p_dsr});
            n_q2   = (n_cur2 >= {1'b0, p_dsr});
            n_sub1 = n_q1 ? n_cur1 - {1'b0, p_dsr} : n_cur1;
            n_sub2 = n_q2 ? n_cur2 - {1'b0, p_dsr} : n_cur2;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem1[k] <= n_sub1[qrs_pkg::DSR_W-1:0];
            r_rem2[k] <= n_sub2[qrs_pkg::DSR_W-1:0];
            r_dvd1[k] <= {p_dvd1[qrs_pkg::DVD_W-2:0], n_q1};
            r_dvd2[k] <= {p_dvd2[qrs_pkg::DVD_W-2:0], n_q2};
            r_dsr[k]  <= p_dsr;
            r_tag[k]  <= p_tag;
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_quo1 = r_dvd1[N-1];
    assign o_quo2 = r_dvd2[N-1];
    assign o_tag  = r_tag[N-1];

endmodule

### hdl/quadratic_root_solver_core.sv
// Quadratic root solver: discriminant, square root and divider pipelines, output clamp.
// Path: a request passes through the discriminant, square root, numerator, divider
//   and output stages, in that order.
// Throughput: one request per cycle; busy stays low, one bit per stage in the square root and divider.
// Reset: synchronous, active low, clears all valid bits; no results are in flight after.
// The receiver cannot stall; each result is shown for one cycle with o_valid.
module quadratic_root_solver_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [qrs_pkg::COEF_W-1:0]    i_coef_quad,
    input  logic signed [qrs_pkg::COEF_W-1:0]    i_coef_lin,
    input  logic signed [qrs_pkg::COEF_W-1:0]    i_coef_const,
    output logic                                 o_valid,
    output logic        [1:0]                    o_root_kind,
    output logic signed [qrs_pkg::DISC_W-1:0]    o_disc_value,
    output logic signed [qrs_pkg::ROOT_W-1:0]    o_first_value,
    output logic signed [qrs_pkg::ROOT_W-1:0]    o_second_value,
    output logic                                 o_saturated
);

    localparam logic [qrs_pkg::DVD_W-1:0] POS_MAX = qrs_pkg::DVD_W'(64'h7FFF_FFFF);
    localparam logic [qrs_pkg::DVD_W-1:0] NEG_MAX = qrs_pkg::DVD_W'(64'h8000_0000);

    logic                           d_vld;
    logic [qrs_pkg::RAD_W-1:0]      d_rad;
    qrs_pkg::t_sq_tag               d_tag;
    logic                           s_vld;
    logic [qrs_pkg::SQ_W-1:0]       s_root;
    qrs_pkg::t_sq_tag               s_tag;

    logic                           r_nvld;
    logic [qrs_pkg::DVD_W-1:0]      r_dvd1;
    logic [qrs_pkg::DVD_W-1:0]      r_dvd2;
    logic [qrs_pkg::DSR_W-1:0]      r_dsr;
    qrs_pkg::t_dv_tag               r_dtag;

    logic                           q_vld;
    logic [qrs_pkg::DVD_W-1:0]      q_quo1;
    logic [qrs_pkg::DVD_W-1:0]      q_quo2;
    qrs_pkg::t_dv_tag               q_tag;

    logic signed [qrs_pkg::NUM_W-1:0] n_negb;
    logic signed [qrs_pkg::NUM_W-1:0] n_s;
    logic signed [qrs_pkg::NUM_W-1:0] n_num1;
    logic signed [qrs_pkg::NUM_W-1:0] n_num2;
    logic        [qrs_pkg::NUM_W-1:0] n_mag1;
    logic        [qrs_pkg::NUM_W-1:0] n_mag2;
    qrs_pkg::t_dv_tag                 n_dtag;

    logic [qrs_pkg::ROOT_W-1:0]     n_v1;
    logic [qrs_pkg::ROOT_W-1:0]     n_v2;
    logic                           n_sat1;
    logic                           n_sat2;

    assign busy = 1'b0;

    qrs_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_a     (i_coef_quad),
        .i_b     (i_coef_lin),
        .i_c     (i_coef_const),
        .o_vld   (d_vld),
        .o_rad   (d_rad),
        .o_tag   (d_tag)
    );

    qrs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (d_vld),
        .i_rad   (d_rad),
        .i_tag   (d_tag),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_tag   (s_tag)
    );

    always_comb begin
        n_negb = qrs_pkg::NUM_W'(s_tag.negb);
        n_s    = $signed({{(qrs_pkg::NUM_W - qrs_pkg::SQ_W){1'b0}}, s_root});
        case (s_tag.kind)
            qrs_pkg::KIND_TWO: begin
                n_num1 = n_negb + n_s;
                n_num2 = n_negb - n_s;
            end
            qrs_pkg::KIND_CPLX: begin
                n_num1 = n_negb;
                n_num2 = n_s;
            end
            default: begin
                n_num1 = n_negb;
                n_num2 = '0;
            end
        endcase
        n_mag1 = n_num1[qrs_pkg::NUM_W-1] ? -n_num1 : n_num1;
        n_mag2 = n_num2[qrs_pkg::NUM_W-1] ? -n_num2 : n_num2;
        n_dtag.kind = s_tag.kind;
        n_dtag.disc = s_tag.disc;
        n_dtag.neg1 = n_num1[qrs_pkg::NUM_W-1] ^ s_tag.a_neg;
        n_dtag.neg2 = n_num2[qrs_pkg::NUM_W-1] ^ s_tag.a_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvld <= 1'b0;
        end else begin
            r_nvld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd1 <= {n_mag1, {qrs_pkg::COEF_FRAC{1'b0}}};
        r_dvd2 <= {n_mag2, {qrs_pkg::COEF_FRAC{1'b0}}};
        r_dsr  <= s_tag.dmag;
        r_dtag <= n_dtag;
    end

    qrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_nvld),
        .i_dvd1  (r_dvd1),
        .i_dvd2  (r_dvd2),
        .i_dsr   (r_dsr),
        .i_tag   (r_dtag),
        .o_vld   (q_vld),
        .o_quo1  (q_quo1),
        .o_quo2  (q_quo2),
        .o_tag   (q_tag)
    );

    always_comb begin
        if (q_tag.neg1) begin
            n_sat1 = (q_quo1 > NEG_MAX);
            n_v1   = n_sat1 ? NEG_MAX[qrs_pkg::ROOT_W-1:0] : -q_quo1[qrs_pkg::ROOT_W-1:0];
        end else begin
            n_sat1 = (q_quo1 > POS_MAX);
            n_v1   = n_sat1 ? POS_MAX[qrs_pkg::ROOT_W-1:0] : q_quo1[qrs_pkg::ROOT_W-1:0];
        end
        if (q_tag.neg2) begin
            n_sat2 = (q_quo2 > NEG_MAX);
            n_v2   = n_sat2 ? NEG_MAX[qrs_pkg::ROOT_W-1:0] : -q_quo2[qrs_pkg::ROOT_W-1:0];
        end else begin
            n_sat2 = (q_quo2 > POS_MAX);
            n_v2   = n_sat2 ? POS_MAX[qrs_pkg::ROOT_W-1:0] : q_quo2[qrs_pkg::ROOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= q_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_root_kind  <= q_tag.kind;
        o_disc_value <= q_tag.disc;
        case (q_tag.kind)
            qrs_pkg::KIND_AZERO: begin
                o_first_value  <= '0;
                o_second_value <= '0;
                o_saturated    <= 1'b0;
            end
            qrs_pkg::KIND_ONE: begin
                o_first_value  <= n_v1;
                o_second_value <= '0;
                o_saturated    <= n_sat1;
            end
            default: begin
                o_first_value  <= n_v1;
                o_second_value <= n_v2;
                o_saturated    <= n_sat1 | n_sat2;
            end
        endcase
    end

    a_two_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_TWO |-> o_disc_value > 0)
        else $error("two real roots without positive discriminant");

    a_cplx_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_CPLX |-> o_disc_value < 0)
        else $error("complex pair without negative discriminant");

    a_azero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_kind == qrs_pkg::KIND_AZERO |->
        o_first_value == 0 && o_second_value == 0 && !o_saturated)
        else $error("zero a result not cleared");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_vld |=> r_nvld)
        else $error("numerator stage lost a request");

endmodule

### tb/sv/quadratic_root_solver_core_test.sv
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 1ps

class root_scoreboard;
    typedef struct {
        logic [1:0]         kind;
        logic signed [33:0] disc;
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic               sat;
    } root_exp_t;

    root_exp_t pending[$];
    int        errors;

    function new();
        errors = 0;
    endfunction

    static function longint unsigned isqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function longint div_clamp(longint num, longint a, inout logic sat);
        longint q;
        q = (num * 256) / (2 * a);
        if (q > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (q < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return q;
    endfunction

    function void note_request(logic signed [15:0] qa, logic signed [15:0] qb,
                               logic signed [15:0] qc);
        root_exp_t e;
        longint a, b, c, d, negb, s;
        logic sat;
        a = qa;
        b = qb;
        c = qc;
        d = b * b - 4 * a * c;
        negb = -b * 256;
        sat = 1'b0;
        e.r1 = 0;
        e.r2 = 0;
        if (a == 0) begin
            e.kind = qrs_pkg::KIND_AZERO;
        end else if (d > 0) begin
            s = longint'(isqrt(longint'(d) << 16));
            e.kind = qrs_pkg::KIND_TWO;
            e.r1 = div_clamp(negb + s, a, sat);
            e.r2 = div_clamp(negb - s, a, sat);
        end else if (d == 0) begin
            e.kind = qrs_pkg::KIND_ONE;
            e.r1 = div_clamp(negb, a, sat);
        end else begin
            s = longint'(isqrt(longint'(-d) << 16));
            e.kind = qrs_pkg::KIND_CPLX;
            e.r1 = div_clamp(negb, a, sat);
            e.r2 = div_clamp(s, a, sat);
        end
        e.disc = d[33:0];
        e.sat  = sat;
        pending.push_back(e);
    endfunction

    function void check_result(logic [1:0] kind, logic signed [33:0] disc,
                               logic signed [31:0] r1, logic signed [31:0] r2,
                               logic sat);
        root_exp_t e;
        if (pending.size() == 0) begin
            $error("unexpected result");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (kind !== e.kind) begin
            $error("root_kind expected %0d actual %0d", e.kind, kind);
            errors++;
        end
        if (disc !== e.disc) begin
            $error("disc_value expected %0d actual %0d", e.disc, disc);
            errors++;
        end
        if (r1 !== e.r1) begin
            $error("first_value expected %0d actual %0d", e.r1, r1);
            errors++;
        end
        if (r2 !== e.r2) begin
            $error("second_value expected %0d actual %0d", e.r2, r2);
            errors++;
        end
        if (sat !== e.sat) begin
            $error("saturated expected %0d actual %0d", e.sat, sat);
            errors++;
        end
    endfunction
endclass

module quadratic_root_solver_core_test;

    localparam int WATCHDOG = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [15:0] i_coef_quad = '0;
    logic signed [15:0] i_coef_lin = '0;
    logic signed [15:0] i_coef_const = '0;
    logic o_valid;
    logic [1:0] o_root_kind;
    logic signed [qrs_pkg::DISC_W-1:0] o_disc_value;
    logic signed [31:0] o_first_value;
    logic signed [31:0] o_second_value;
    logic o_saturated;

    root_scoreboard sb;
    int idle_cycles = 0;
    int idle_pct;

    quadratic_root_solver_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_coef_quad(i_coef_quad), .i_coef_lin(i_coef_lin),
        .i_coef_const(i_coef_const), .o_valid(o_valid),
        .o_root_kind(o_root_kind), .o_disc_value(o_disc_value),
        .o_first_value(o_first_value), .o_second_value(o_second_value),
        .o_saturated(o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_request(i_coef_quad, i_coef_lin, i_coef_const);
        end
        if (i_rst_n && o_valid) begin
            sb.check_result(o_root_kind, o_disc_value, o_first_value,
                            o_second_value, o_saturated);
        end
        if (i_rst_n && ((start && !busy) || o_valid)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_request(logic signed [15:0] qa, logic signed [15:0] qb,
                                logic signed [15:0] qc);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_coef_quad  <= qa;
        i_coef_lin   <= qb;
        i_coef_const <= qc;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(512)) - 256);
            3: return 16'(int'($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int n);
        logic signed [15:0] qa, qb, qc;
        for (int k = 0; k < n; k++) begin
            qa = rand_coef();
            qb = rand_coef();
            qc = rand_coef();
            if ($urandom_range(9) == 0) begin
                qc = 16'((longint'(qb) * qb) / (4 * ((qa == 0) ? 1 : qa)));
            end
            if ($urandom_range(19) == 0) qa = 0;
            send_request(qa, qb, qc);
        end
    endtask

    initial begin
        sb = new();
        idle_pct = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_request(16'sh0100, 16'sh0000, 16'shff00);
        send_request(16'sh0100, 16'shfe00, 16'sh0100);
        send_request(16'sh0100, 16'sh0000, 16'sh0100);
        send_request(16'sh0000, 16'sh0300, 16'sh0100);
        send_request(16'sh0000, 16'sh0000, 16'sh0000);
        send_request(16'sh0001, 16'sh7fff, 16'sh8000);
        send_request(16'sh0001, 16'sh8000, 16'sh7fff);
        send_request(16'sh8000, 16'sh8000, 16'sh8000);
        send_request(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_request(16'sh8000, 16'sh7fff, 16'sh7fff);
        send_request(16'shffff, 16'sh0000, 16'sh0000);
        send_request(16'sh0001, 16'sh0001, 16'sh0001);
        send_request(16'shffff, 16'sh8000, 16'sh0000);
        send_request(16'sh0001, 16'sh0002, 16'sh0001);
        send_request(16'sh7fff, 16'sh0000, 16'sh8000);
        send_request(16'shff00, 16'sh0400, 16'sh0300);
        drain();
        idle_pct = 23;
        random_phase(480);
        drain();
        idle_pct = 52;
        random_phase(480);
        idle_pct = 0;
        random_phase(480);
        drain();
        repeat (80) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
